FILE: hdl/rlcw_pkg.sv
// ---------------------------------------------------------------------------
// rlcw_pkg: shared types and helpers for the rainbow color wheel
// Word layouts passed between front, queue and back, plus the divider step
// and the six-segment wheel lookup.
// ---------------------------------------------------------------------------
package rlcw_pkg;

    localparam int          QUEUE_DEPTH_DEFAULT = 2;
    localparam logic [7:0]  LED_COUNT_RESET     = 8'd255;
    localparam logic [7:0]  WHEEL_FULL          = 8'd255;

    // steps of the shifting dividers
    localparam int MOD_STEPS = 9;   // 9-bit dividend reduced mod count
    localparam int QUO_STEPS = 9;   // low quotient bits of the wheel phase

    // wheel segments
    localparam logic [2:0] SEG_RED_GREEN_UP  = 3'd0;
    localparam logic [2:0] SEG_RED_DOWN      = 3'd1;
    localparam logic [2:0] SEG_BLUE_UP       = 3'd2;
    localparam logic [2:0] SEG_GREEN_DOWN    = 3'd3;
    localparam logic [2:0] SEG_RED_UP        = 3'd4;

    // word held in the queue between front and back
    typedef struct packed {
        logic [8:0] sum;
        logic [7:0] step;
    } item_t;

    // remainder stages
    typedef struct packed {
        logic [8:0] sum;
        logic [7:0] step;
        logic [7:0] rem_pos;
        logic [7:0] rem_step;
    } mod_t;

    // quotient stages
    typedef struct packed {
        logic [7:0] pos;
        logic [7:0] rem;
        logic [1:0] top;
        logic [8:0] quo;
    } quo_t;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } color_t;

    // one restoring step: shift a dividend bit in, subtract if it fits
    function automatic logic [7:0] mod_shift_sub(input logic [7:0] rem,
                                                 input logic       din,
                                                 input logic [7:0] n);
        logic [8:0] t;
        t = {rem, din};
        if (t >= {1'b0, n})
        begin
            t = t - {1'b0, n};
        end
        return t[7:0];
    endfunction

    // phase (0..1535) to color
    function automatic color_t wheel_color(input logic [10:0] q);
        color_t     c;
        logic [7:0] x;
        x = q[7:0];
        unique case (q[10:8])
            SEG_RED_GREEN_UP: c = '{red: WHEEL_FULL,     green: x,              blue: 8'd0};
            SEG_RED_DOWN:     c = '{red: WHEEL_FULL - x, green: WHEEL_FULL,     blue: 8'd0};
            SEG_BLUE_UP:      c = '{red: 8'd0,           green: WHEEL_FULL,     blue: x};
            SEG_GREEN_DOWN:   c = '{red: 8'd0,           green: WHEEL_FULL - x, blue: WHEEL_FULL};
            SEG_RED_UP:       c = '{red: x,              green: 8'd0,           blue: WHEEL_FULL};
            default:          c = '{red: WHEEL_FULL,     green: 8'd0,
                                    blue: WHEEL_FULL - x};
        endcase
        return c;
    endfunction

endpackage

FILE: hdl/rlcw_front.sv
// ---------------------------------------------------------------------------
// rlcw_front: input stage of the color wheel
// Takes step/rotation words, forms the 9-bit position sum and hands the
// word to the queue.
// ---------------------------------------------------------------------------
module rlcw_front (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [15:0]          s_tdata,    // [7:0] step, [15:8] rotation
    output logic                 out_valid,
    input  logic                 out_ready,
    output rlcw_pkg::item_t      out_item
);
    import rlcw_pkg::*;

    logic  vld_reg;
    logic  vld_next;
    item_t item_reg;

    // free when empty or when the held word moves on this cycle
    assign s_tready  = !vld_reg || out_ready;
    assign out_valid = vld_reg;
    assign out_item  = item_reg;

    always_comb
    begin
        vld_next = vld_reg;
        if (s_tready)
        begin
            vld_next = s_tvalid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    // sum kept at 9 bits, no wrap
    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            item_reg.sum  <= {1'b0, s_tdata[7:0]} + {1'b0, s_tdata[15:8]};
            item_reg.step <= s_tdata[7:0];
        end
    end

endmodule

FILE: hdl/rlcw_queue.sv
// ---------------------------------------------------------------------------
// rlcw_queue: short FIFO between front and back
// Register-based; push and pop may happen in the same cycle.
// ---------------------------------------------------------------------------
module rlcw_queue #(
    parameter int DEPTH = rlcw_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  rlcw_pkg::item_t      in_item,
    output logic                 out_valid,
    input  logic                 out_ready,
    output rlcw_pkg::item_t      out_item
);
    import rlcw_pkg::*;

    localparam int PTR_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int COUNT_W = $clog2(DEPTH + 1);

    item_t              mem [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [COUNT_W-1:0] count_reg, count_next;
    logic               push;
    logic               pop;

    assign in_ready  = (count_reg != COUNT_W'(DEPTH));
    assign out_valid = (count_reg != '0);
    assign out_item  = mem[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    // pointer and fill bookkeeping
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= in_item;
        end
    end

endmodule

FILE: hdl/rlcw_back.sv
// ---------------------------------------------------------------------------
// rlcw_back: divider pipeline and color lookup
// Nine remainder stages give position and step mod count; one stage takes
// the top of 1536*cs/n, nine more stages the low quotient bits, then the
// wheel lookup lands in the output register.
// ---------------------------------------------------------------------------
module rlcw_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic [7:0]           n,          // effective led count, 1..255
    input  logic                 in_valid,
    output logic                 in_ready,
    input  rlcw_pkg::item_t      in_item,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [31:0]          out_data    // position, red, green, blue
);
    import rlcw_pkg::*;

    logic                  en;
    mod_t                  mod_in      [MOD_STEPS];
    mod_t                  mod_reg     [MOD_STEPS];
    logic [MOD_STEPS-1:0]  mod_vld_in;
    logic [MOD_STEPS-1:0]  mod_vld_reg;
    quo_t                  tri_next;
    quo_t                  tri_reg;
    logic                  tri_vld_reg;
    quo_t                  quo_in      [QUO_STEPS];
    quo_t                  quo_reg     [QUO_STEPS];
    logic [QUO_STEPS-1:0]  quo_vld_in;
    logic [QUO_STEPS-1:0]  quo_vld_reg;
    color_t                color;
    logic [31:0]           out_reg;
    logic                  out_vld_reg;

    // whole pipe advances unless a finished word is stuck at the output
    assign en        = !out_vld_reg || out_ready;
    assign in_ready  = en;
    assign out_valid = out_vld_reg;
    assign out_data  = out_reg;

    // remainder stages, MSB of the dividend first
    for (genvar k = 0; k < MOD_STEPS; k++)
    begin : g_mod
        localparam int BIT = MOD_STEPS - 1 - k;
        logic [8:0] step_ext;

        if (k == 0)
        begin : g_first
            assign mod_in[k]     = '{sum: in_item.sum, step: in_item.step,
                                     rem_pos: 8'd0, rem_step: 8'd0};
            assign mod_vld_in[k] = in_valid;
        end
        else
        begin : g_rest
            assign mod_in[k]     = mod_reg[k-1];
            assign mod_vld_in[k] = mod_vld_reg[k-1];
        end

        assign step_ext = {1'b0, mod_in[k].step};

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                mod_vld_reg[k] <= 1'b0;
            end
            else if (en)
            begin
                mod_vld_reg[k] <= mod_vld_in[k];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                mod_reg[k].sum      <= mod_in[k].sum;
                mod_reg[k].step     <= mod_in[k].step;
                mod_reg[k].rem_pos  <= mod_shift_sub(mod_in[k].rem_pos,
                                                     mod_in[k].sum[BIT], n);
                mod_reg[k].rem_step <= mod_shift_sub(mod_in[k].rem_step,
                                                     step_ext[BIT], n);
            end
        end
    end

    // top quotient bits: 3*cs < 3n, so at most two subtractions
    always_comb
    begin
        logic [9:0] a;
        logic [9:0] n1;
        logic [9:0] n2;
        a  = {2'b0, mod_reg[MOD_STEPS-1].rem_step}
           + {1'b0, mod_reg[MOD_STEPS-1].rem_step, 1'b0};
        n1 = {2'b0, n};
        n2 = {1'b0, n, 1'b0};
        tri_next.pos = mod_reg[MOD_STEPS-1].rem_pos;
        tri_next.quo = 9'd0;
        if (a >= n2)
        begin
            tri_next.top = 2'd2;
            tri_next.rem = 8'(a - n2);
        end
        else if (a >= n1)
        begin
            tri_next.top = 2'd1;
            tri_next.rem = 8'(a - n1);
        end
        else
        begin
            tri_next.top = 2'd0;
            tri_next.rem = a[7:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tri_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            tri_vld_reg <= mod_vld_reg[MOD_STEPS-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            tri_reg <= tri_next;
        end
    end

    // low quotient bits, dividend bits below are all zero
    for (genvar j = 0; j < QUO_STEPS; j++)
    begin : g_quo
        logic [8:0] t;

        if (j == 0)
        begin : g_first
            assign quo_in[j]     = tri_reg;
            assign quo_vld_in[j] = tri_vld_reg;
        end
        else
        begin : g_rest
            assign quo_in[j]     = quo_reg[j-1];
            assign quo_vld_in[j] = quo_vld_reg[j-1];
        end

        assign t = {quo_in[j].rem, 1'b0};

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                quo_vld_reg[j] <= 1'b0;
            end
            else if (en)
            begin
                quo_vld_reg[j] <= quo_vld_in[j];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                quo_reg[j].pos <= quo_in[j].pos;
                quo_reg[j].top <= quo_in[j].top;
                if (t >= {1'b0, n})
                begin
                    quo_reg[j].rem <= 8'(t - {1'b0, n});
                    quo_reg[j].quo <= {quo_in[j].quo[7:0], 1'b1};
                end
                else
                begin
                    quo_reg[j].rem <= t[7:0];
                    quo_reg[j].quo <= {quo_in[j].quo[7:0], 1'b0};
                end
            end
        end
    end

    // wheel lookup into the output register
    assign color = wheel_color({quo_reg[QUO_STEPS-1].top, quo_reg[QUO_STEPS-1].quo});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            out_vld_reg <= quo_vld_reg[QUO_STEPS-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_reg <= {color.blue, color.green, color.red, quo_reg[QUO_STEPS-1].pos};
        end
    end

endmodule

FILE: hdl/rainbow_led_color_wheel_unit.sv
// ---------------------------------------------------------------------------
// rainbow_led_color_wheel_unit: six-segment rainbow color wheel
// Maps an LED step and rotation to a strip position and an RGB color.
// ---------------------------------------------------------------------------
// Usage:
//   Input stream s_*: one word per LED, step in bits [7:0], rotation in
//   bits [15:8]. Output stream m_*: position, red, green, blue, one byte
//   each from bit 0 up. One output word per input word, in order.
//   cfg_we/cfg_wdata set led_count (the wheel divisor); write it only when
//   no word is in flight. A count of zero behaves as one.
//   From input acceptance to m_tvalid a word passes one front register,
//   one queue slot, nine remainder stages, one top-quotient stage, nine
//   quotient stages and the output register.
//   Throughput is one word per cycle; each divider stage resolves one bit.
//   When m_tready is low the divider pipe holds; the front and the queue
//   keep taking words until the queue fills, then s_tready drops.
//   Reset sets led_count to 255 and empties front, queue and pipe.
// ---------------------------------------------------------------------------
module rainbow_led_color_wheel_unit #(
    parameter int QUEUE_DEPTH = rlcw_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,     // [7:0] step, [15:8] rotation
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,     // [7:0] position, [15:8] red,
                                     // [23:16] green, [31:24] blue
    input  logic        cfg_we,
    input  logic [7:0]  cfg_wdata    // led_count
);
    import rlcw_pkg::*;

    logic [7:0] led_count_reg;
    logic [7:0] led_count_next;
    logic [7:0] n_eff;
    logic       front_valid;
    logic       front_ready;
    item_t      front_item;
    logic       queue_valid;
    logic       queue_ready;
    item_t      queue_item;

    // count register
    assign led_count_next = cfg_we ? cfg_wdata : led_count_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            led_count_reg <= LED_COUNT_RESET;
        end
        else
        begin
            led_count_reg <= led_count_next;
        end
    end

    assign n_eff = (led_count_reg == 8'd0) ? 8'd1 : led_count_reg;

    rlcw_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .out_valid (front_valid),
        .out_ready (front_ready),
        .out_item  (front_item)
    );

    rlcw_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (front_valid),
        .in_ready  (front_ready),
        .in_item   (front_item),
        .out_valid (queue_valid),
        .out_ready (queue_ready),
        .out_item  (queue_item)
    );

    rlcw_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .n         (n_eff),
        .in_valid  (queue_valid),
        .in_ready  (queue_ready),
        .in_item   (queue_item),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (m_tdata)
    );

`ifndef SYNTHESIS
    // every wheel color has one channel full and one channel off
    a_color_shape: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[15:8] == 8'd255 || m_tdata[23:16] == 8'd255 ||
                      m_tdata[31:24] == 8'd255) &&
                     (m_tdata[15:8] == 8'd0 || m_tdata[23:16] == 8'd0 ||
                      m_tdata[31:24] == 8'd0))
        else $error("wheel color outside the six segments");

    // position is a true remainder of the count
    a_position_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[7:0] < n_eff))
        else $error("position not below led count");

    // a word in the front register with the queue full must block input
    a_front_block: assert property (@(posedge clk) disable iff (!rst_n)
        (front_valid && !front_ready) |-> !s_tready)
        else $error("input taken while front is blocked");
`endif

endmodule

FILE: tb/tb_top.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_top: self-checking bench for the rainbow color wheel unit
// Streams step/rotation words into the wheel and checks every output word
// against a local color wheel predictor. A directed table runs first, then
// random words across a range of LED counts, with random gaps and stalls on
// both streams.
// ---------------------------------------------------------------------------
module tb_top;

    localparam int unsigned PHASE_STEPS = 1536;  // six segments of 256
    localparam int unsigned IDLE_LIMIT  = 2000;  // cycles with no word moving
    localparam int unsigned TAIL_CYCLES = 40;    // idle tail after the final drain
    localparam int unsigned PHASE_WORDS = 82;
    localparam int unsigned MAX_PRINTS  = 40;

    // one pixel as it leaves the block
    typedef struct packed {
        logic [7:0] pos;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } wheel_px_t;

    // one row of the directed table
    typedef struct packed {
        logic [7:0] count;
        logic [7:0] step;
        logic [7:0] rot;
        logic       typed;
        wheel_px_t  px;
    } wheel_row_t;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [15:0] s_tdata;     // [7:0] step, [15:8] rotation
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;     // [7:0] position, [15:8] red, [23:16] green,
                              // [31:24] blue
    logic        cfg_we;
    logic [7:0]  cfg_wdata;

    wheel_px_t   expected_px[$];
    wheel_row_t  wheel_rows[$];
    logic [7:0]  led_count_m;
    int unsigned mismatches;
    bit          tx_burst;
    bit          rx_burst;

    rainbow_led_color_wheel_unit DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // wheel predictor: position plus six-segment color for one step
    function automatic wheel_px_t predict_pixel(input logic [7:0] step,
                                                input logic [7:0] rot,
                                                input logic [7:0] count);
        wheel_px_t   px;
        int unsigned n;
        int unsigned wrapped;
        logic [10:0] phase;
        logic [7:0]  ramp;
        n       = (count == 8'd0) ? 1 : int'(count);
        wrapped = int'(step) % n;
        phase   = 11'((PHASE_STEPS * wrapped) / n);
        ramp    = phase[7:0];
        px.pos  = 8'((int'(step) + int'(rot)) % n);
        case (phase[10:8])
            rlcw_pkg::SEG_RED_GREEN_UP:
            begin
                px.red = rlcw_pkg::WHEEL_FULL; px.green = ramp; px.blue = 8'd0;
            end
            rlcw_pkg::SEG_RED_DOWN:
            begin
                px.red   = rlcw_pkg::WHEEL_FULL - ramp;
                px.green = rlcw_pkg::WHEEL_FULL;
                px.blue  = 8'd0;
            end
            rlcw_pkg::SEG_BLUE_UP:
            begin
                px.red = 8'd0; px.green = rlcw_pkg::WHEEL_FULL; px.blue = ramp;
            end
            rlcw_pkg::SEG_GREEN_DOWN:
            begin
                px.red   = 8'd0;
                px.green = rlcw_pkg::WHEEL_FULL - ramp;
                px.blue  = rlcw_pkg::WHEEL_FULL;
            end
            rlcw_pkg::SEG_RED_UP:
            begin
                px.red = ramp; px.green = 8'd0; px.blue = rlcw_pkg::WHEEL_FULL;
            end
            default:
            begin
                px.red   = rlcw_pkg::WHEEL_FULL;
                px.green = 8'd0;
                px.blue  = rlcw_pkg::WHEEL_FULL - ramp;
            end
        endcase
        return px;
    endfunction

    function automatic wheel_px_t make_px(input logic [7:0] pos, input logic [7:0] r,
                                          input logic [7:0] g, input logic [7:0] b);
        wheel_px_t px;
        px.pos = pos; px.red = r; px.green = g; px.blue = b;
        return px;
    endfunction

    // add a row; typed rows carry a hand-written result
    task automatic add_row(input logic [7:0] count, input logic [7:0] step,
                           input logic [7:0] rot, input logic typed,
                           input wheel_px_t px);
        wheel_row_t row;
        row.count = count; row.step = step; row.rot = rot;
        row.typed = typed; row.px = px;
        wheel_rows.push_back(row);
    endtask

    task automatic report_mismatch(input string msg);
        if (mismatches < MAX_PRINTS)
        begin
            $display("%0t ns  mismatch: %s", $time, msg);
        end
        mismatches++;
    endtask

    // present one word after a random gap (none in a burst), record its pixel when taken
    task automatic send_word(input logic [7:0] step, input logic [7:0] rot,
                             input wheel_px_t px);
        int unsigned gap;
        gap = tx_burst ? 0 : $urandom_range(0, 12);
        @(negedge clk);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {rot, step};
        do @(posedge clk); while (!s_tready);
        expected_px.push_back(px);
    endtask

    // stop sending and let every pending pixel come out
    task automatic drain_pixels();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (expected_px.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic set_led_count(input logic [7:0] count);
        drain_pixels();
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= count;
        @(negedge clk);
        cfg_we    <= 1'b0;
        led_count_m = count;
    endtask

    // stimulus: directed table, then random phases over several LED counts
    initial
    begin : stimulus
        logic [7:0]  phase_counts[14];
        wheel_row_t  row;
        wheel_px_t   px;
        logic [7:0]  step;
        logic [7:0]  rot;
        int unsigned eff;
        int unsigned pause_at;
        s_tvalid    = 1'b0;
        s_tdata     = 16'd0;
        m_tready    = 1'b0;
        cfg_we      = 1'b0;
        cfg_wdata   = 8'd0;
        rst_n       = 1'b0;
        mismatches  = 0;
        tx_burst    = 1'b0;
        rx_burst    = 1'b0;
        led_count_m = 8'd255;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // reset count, zero and full-scale inputs, step beyond the count
        add_row(8'd255, 8'd0,   8'd0,   1'b1, make_px(8'd0, 8'd255, 8'd0, 8'd0));
        add_row(8'd255, 8'd255, 8'd255, 1'b1, make_px(8'd0, 8'd255, 8'd0, 8'd0));
        add_row(8'd255, 8'd254, 8'd254, 1'b0, '0);
        add_row(8'd255, 8'd128, 8'd127, 1'b0, '0);
        add_row(8'd255, 8'd1,   8'd0,   1'b0, '0);
        // zero count acts as one
        add_row(8'd0,   8'd200, 8'd100, 1'b1, make_px(8'd0, 8'd255, 8'd0, 8'd0));
        add_row(8'd0,   8'd255, 8'd255, 1'b1, make_px(8'd0, 8'd255, 8'd0, 8'd0));
        add_row(8'd1,   8'd0,   8'd255, 1'b1, make_px(8'd0, 8'd255, 8'd0, 8'd0));
        add_row(8'd1,   8'd170, 8'd85,  1'b1, make_px(8'd0, 8'd255, 8'd0, 8'd0));
        // six LEDs: one step per segment start, then wrapping sums; two LEDs
        add_row(8'd6, 8'd0, 8'd0, 1'b1, make_px(8'd0, 8'd255, 8'd0,   8'd0));
        add_row(8'd6, 8'd1, 8'd0, 1'b1, make_px(8'd1, 8'd255, 8'd255, 8'd0));
        add_row(8'd6, 8'd2, 8'd0, 1'b1, make_px(8'd2, 8'd0,   8'd255, 8'd0));
        add_row(8'd6, 8'd3, 8'd0, 1'b1, make_px(8'd3, 8'd0,   8'd255, 8'd255));
        add_row(8'd6, 8'd4, 8'd0, 1'b1, make_px(8'd4, 8'd0,   8'd0,   8'd255));
        add_row(8'd6, 8'd5, 8'd0, 1'b1, make_px(8'd5, 8'd255, 8'd0,   8'd255));
        add_row(8'd6, 8'd6, 8'd250, 1'b1, make_px(8'd4, 8'd255, 8'd0, 8'd0));
        add_row(8'd6, 8'd5, 8'd255, 1'b1, make_px(8'd2, 8'd255, 8'd0, 8'd255));
        add_row(8'd2, 8'd1, 8'd1,   1'b1, make_px(8'd0, 8'd0, 8'd255, 8'd255));
        // mid-segment ramps and large sums
        add_row(8'd12,  8'd1,   8'd0,   1'b0, '0);
        add_row(8'd12,  8'd11,  8'd255, 1'b0, '0);
        add_row(8'd200, 8'd199, 8'd255, 1'b0, '0);
        add_row(8'd128, 8'd127, 8'd128, 1'b0, '0);

        foreach (wheel_rows[k])
        begin
            row = wheel_rows[k];
            if (row.count != led_count_m)
            begin
                set_led_count(row.count);
            end
            px = row.typed ? row.px : predict_pixel(row.step, row.rot, led_count_m);
            send_word(row.step, row.rot, px);
        end

        phase_counts = '{8'd1, 8'd0, 8'd2, 8'd3, 8'd5, 8'd6, 8'd17, 8'd100,
                         8'd128, 8'd200, 8'd254, 8'd255, 8'd0, 8'd0};
        phase_counts[12] = 8'($urandom_range(1, 255));
        phase_counts[13] = 8'($urandom_range(1, 255));

        foreach (phase_counts[p])
        begin
            set_led_count(phase_counts[p]);
            eff      = (led_count_m == 8'd0) ? 1 : int'(led_count_m);
            tx_burst = ($urandom_range(0, 3) == 0);
            pause_at = $urandom_range(10, PHASE_WORDS - 10);
            for (int unsigned i = 0; i < PHASE_WORDS; i++)
            begin
                // hold off until the pipe is empty once per phase
                if (i == pause_at)
                begin
                    drain_pixels();
                    tx_burst = ($urandom_range(0, 3) == 0);
                end
                // mostly steps on the strip, some beyond it
                if ($urandom_range(0, 3) != 0)
                begin
                    step = 8'($urandom_range(0, eff - 1));
                end
                else
                begin
                    step = 8'($urandom_range(0, 255));
                end
                case ($urandom_range(0, 7))
                    0:       rot = 8'd0;
                    1:       rot = 8'd255;
                    default: rot = 8'($urandom_range(0, 255));
                endcase
                send_word(step, rot, predict_pixel(step, rot, led_count_m));
            end
        end

        drain_pixels();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatches == 0)
        begin
            $display("Regression PASS");
        end
        else
        begin
            $display("Regression FAIL");
        end
        $finish;
    end

    // output side: random stalls, check each word against the oldest pixel
    initial
    begin : sink
        int unsigned stall;
        int unsigned taken;
        wheel_px_t   got;
        wheel_px_t   want;
        taken = 0;
        @(posedge rst_n);
        forever
        begin
            if (taken % 50 == 0)
            begin
                rx_burst = ($urandom_range(0, 3) == 0);
            end
            @(negedge clk);
            stall = rx_burst ? 0 : $urandom_range(0, 12);
            if (stall > 0)
            begin
                m_tready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            m_tready <= 1'b1;
            do @(posedge clk); while (!m_tvalid);
            got = make_px(m_tdata[7:0], m_tdata[15:8], m_tdata[23:16], m_tdata[31:24]);
            taken++;
            if (expected_px.size() == 0)
            begin
                report_mismatch($sformatf("word %0h with nothing expected", m_tdata));
            end
            else
            begin
                want = expected_px.pop_front();
                if (got.pos !== want.pos)
                begin
                    report_mismatch($sformatf("word %0d position got %0d want %0d",
                                              taken, got.pos, want.pos));
                end
                if (got.red !== want.red)
                begin
                    report_mismatch($sformatf("word %0d red got %0d want %0d",
                                              taken, got.red, want.red));
                end
                if (got.green !== want.green)
                begin
                    report_mismatch($sformatf("word %0d green got %0d want %0d",
                                              taken, got.green, want.green));
                end
                if (got.blue !== want.blue)
                begin
                    report_mismatch($sformatf("word %0d blue got %0d want %0d",
                                              taken, got.blue, want.blue));
                end
            end
        end
    end

    // watchdog: too long with no word moving on either stream
    initial
    begin : watchdog
        int unsigned quiet;
        quiet = 0;
        while (quiet < IDLE_LIMIT)
        begin
            @(posedge clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            begin
                quiet = 0;
            end
            else
            begin
                quiet++;
            end
        end
        $display("%0t ns  timeout, %0d pixels pending", $time, expected_px.size());
        $display("Regression FAIL");
        $finish;
    end

endmodule
